// ===== src/ccs_pkg.sv =====
`default_nettype none

package ccs_pkg;

    // Characters that steer the scanner.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Default depth of the queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // Scanner modes.
    typedef enum logic [3:0] {
        M_NORMAL     = 4'd0,
        M_SLASH      = 4'd1,
        M_LINE       = 4'd2,
        M_BLOCK      = 4'd3,
        M_BLOCK_STAR = 4'd4,
        M_DQ         = 4'd5,
        M_DQ_ESC     = 4'd6,
        M_SQ         = 4'd7,
        M_SQ_ESC     = 4'd8
    } t_mode;

    // One queued command: one or two output bytes, or the error result.
    typedef struct packed {
        logic       two;
        logic       misparse;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/ccs_front.sv =====
`default_nettype none

module ccs_front (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    input  wire  [7:0]   i_in_byte,
    input  wire          i_end_marker,
    input  wire          i_full,
    output logic         o_push,
    output ccs_pkg::t_cmd o_cmd
);

    ccs_pkg::t_mode r_mode;
    ccs_pkg::t_mode n_mode;
    logic           accept;
    logic           has_res;
    logic           is_quote;

    assign accept   = i_valid && !i_full;
    assign is_quote = (i_in_byte == ccs_pkg::CH_DQUOTE) || (i_in_byte == ccs_pkg::CH_SQUOTE);
    assign o_push   = accept && has_res;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ccs_pkg::M_NORMAL;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    // Next mode and the command that this byte produces.
    always_comb begin
        n_mode       = r_mode;
        has_res      = 1'b0;
        o_cmd.two      = 1'b0;
        o_cmd.misparse = 1'b0;
        o_cmd.b0       = i_in_byte;
        o_cmd.b1       = i_in_byte;
        if (i_end_marker) begin
            n_mode = ccs_pkg::M_NORMAL;
            if (r_mode == ccs_pkg::M_SLASH) begin
                has_res        = 1'b1;
                o_cmd.misparse = 1'b1;
                o_cmd.b0       = 8'h00;
            end
        end else begin
            case (r_mode)
                ccs_pkg::M_SLASH: begin
                    if (i_in_byte == ccs_pkg::CH_STAR) begin
                        n_mode = ccs_pkg::M_BLOCK;
                    end else if (i_in_byte == ccs_pkg::CH_SLASH) begin
                        n_mode = ccs_pkg::M_LINE;
                    end else begin
                        // The held slash goes out ahead of this byte.
                        has_res   = 1'b1;
                        o_cmd.two = 1'b1;
                        o_cmd.b0  = ccs_pkg::CH_SLASH;
                        if (i_in_byte == ccs_pkg::CH_DQUOTE) begin
                            n_mode = ccs_pkg::M_DQ;
                        end else if (i_in_byte == ccs_pkg::CH_SQUOTE) begin
                            n_mode = ccs_pkg::M_SQ;
                        end else begin
                            n_mode = ccs_pkg::M_NORMAL;
                        end
                    end
                end
                ccs_pkg::M_LINE: begin
                    if (i_in_byte == ccs_pkg::CH_NL) begin
                        has_res = 1'b1;
                        n_mode  = ccs_pkg::M_NORMAL;
                    end
                end
                ccs_pkg::M_BLOCK: begin
                    if (i_in_byte == ccs_pkg::CH_STAR) begin
                        n_mode = ccs_pkg::M_BLOCK_STAR;
                    end
                end
                ccs_pkg::M_BLOCK_STAR: begin
                    if (i_in_byte == ccs_pkg::CH_SLASH) begin
                        n_mode = ccs_pkg::M_NORMAL;
                    end else if (i_in_byte != ccs_pkg::CH_STAR) begin
                        n_mode = ccs_pkg::M_BLOCK;
                    end
                end
                ccs_pkg::M_DQ: begin
                    has_res = 1'b1;
                    if (i_in_byte == ccs_pkg::CH_DQUOTE) begin
                        n_mode = ccs_pkg::M_NORMAL;
                    end else if (i_in_byte == ccs_pkg::CH_BSLASH) begin
                        n_mode = ccs_pkg::M_DQ_ESC;
                    end
                end
                ccs_pkg::M_SQ: begin
                    has_res = 1'b1;
                    if (i_in_byte == ccs_pkg::CH_SQUOTE) begin
                        n_mode = ccs_pkg::M_NORMAL;
                    end else if (i_in_byte == ccs_pkg::CH_BSLASH) begin
                        n_mode = ccs_pkg::M_SQ_ESC;
                    end
                end
                ccs_pkg::M_DQ_ESC: begin
                    has_res = 1'b1;
                    n_mode  = ccs_pkg::M_DQ;
                end
                ccs_pkg::M_SQ_ESC: begin
                    has_res = 1'b1;
                    n_mode  = ccs_pkg::M_SQ;
                end
                default: begin
                    // Normal text; unused codes behave the same way.
                    if (i_in_byte == ccs_pkg::CH_SLASH) begin
                        n_mode = ccs_pkg::M_SLASH;
                    end else begin
                        has_res = 1'b1;
                        if (i_in_byte == ccs_pkg::CH_DQUOTE) begin
                            n_mode = ccs_pkg::M_DQ;
                        end else if (is_quote) begin
                            n_mode = ccs_pkg::M_SQ;
                        end else begin
                            n_mode = ccs_pkg::M_NORMAL;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/ccs_fifo.sv =====
`default_nettype none

module ccs_fifo #(
    parameter int Depth = ccs_pkg::QUEUE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  ccs_pkg::t_cmd i_cmd,
    input  wire           i_pop,
    output logic          o_full,
    output logic          o_empty,
    output ccs_pkg::t_cmd o_cmd
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    ccs_pkg::t_cmd   r_mem [Depth];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == FullCnt);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ccs_back.sv =====
`default_nettype none

module ccs_back (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_empty,
    input  ccs_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  wire           i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_misparse,
    output logic          o_run_last
);

    logic       r_valid;
    logic       r_pend;
    logic [7:0] r_b1;
    logic [7:0] r_byte;
    logic       r_misparse;
    logic       r_last;
    logic       load;

    // The output register can take a new result when it is empty or its
    // current result transfers in this cycle.
    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !r_pend && !i_empty;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_empty;
                r_pend  <= !i_empty && i_cmd.two;
            end
        end
    end

    // Result payload; the second byte of a pair waits in r_b1.
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_byte     <= r_b1;
                r_misparse <= 1'b0;
                r_last     <= 1'b1;
            end else if (!i_empty) begin
                r_byte     <= i_cmd.b0;
                r_misparse <= i_cmd.misparse;
                r_last     <= !i_cmd.two;
                r_b1       <= i_cmd.b1;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_misparse = r_misparse;
    assign o_run_last = r_last;

endmodule

`default_nettype wire

// ===== src/c_comment_stripper.sv =====
// C comment stripper: removes block and line comments from a byte stream of
// C source, passing string and character literals through unchanged.
// Input channel: i_valid, o_stall, i_in_byte, i_end_marker. A transfer
// carries one source byte, or an end-of-stream marker when i_end_marker is 1.
// Output channel: o_valid, i_stall, o_out_byte, o_misparse, o_run_last. Each
// input transfer causes zero, one or two results; o_run_last marks the last
// of them, and o_misparse flags a stream that ended right after a lone slash.
// A scanner accepts one byte every cycle while the queue is not full and
// writes its results into a queue of QueueDepth entries; an output stage
// sends one result per cycle while the receiver does not stall. With an
// empty queue, the first result of an item passes the queue and then the
// output register before it is valid. Throughput: one item per cycle while
// the queue is not full, bounded by one result per cycle at the output.
// When the receiver stalls, the held result stays in place, the queue fills,
// and o_stall rises once the queue is full.
// Reset clears the scan mode to normal text, empties the queue and drops
// o_valid.
`default_nettype none

module c_comment_stripper #(
    parameter int QueueDepth = ccs_pkg::QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [7:0] i_in_byte,
    input  wire        i_end_marker,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_misparse,
    output logic       o_run_last
);

    ccs_pkg::t_cmd push_cmd;
    ccs_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    assign o_stall = full;

    // Scanner.
    ccs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_byte    (i_in_byte),
        .i_end_marker (i_end_marker),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Queue between scanner and output stage.
    ccs_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    // Output stage.
    ccs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_misparse (o_misparse),
        .o_run_last (o_run_last)
    );

endmodule

`default_nettype wire
